FILE: src/bwsp_pkg.sv
// Shared types, codes and constants of the battery wake shutdown policy unit.
package bwsp_pkg;

  localparam int unsigned TABLE_DEPTH = 8;
  localparam int unsigned LEVEL_W     = 15;
  localparam int unsigned SEC_W       = 31;
  localparam int unsigned THR_W       = 16;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned CFG_IDX_W   = 2;

  // 86400 = 2^7 * 675: divisibility by the odd part via its modular inverse
  localparam int unsigned DAY_SHIFT = 7;
  localparam int unsigned DAY_ODD   = 675;
  localparam int unsigned ODD_W     = SEC_W - DAY_SHIFT;

  function automatic logic [ODD_W-1:0] odd_inverse(input logic [ODD_W-1:0] d);
    logic [ODD_W-1:0] x;
    x = d;
    for (int k = 0; k < 6; k++) begin
      x = x * (ODD_W'(2) - d * x);
    end
    return x;
  endfunction

  localparam logic [ODD_W-1:0] DAY_INV   = odd_inverse(ODD_W'(DAY_ODD));
  localparam logic [ODD_W-1:0] DAY_LIMIT = ODD_W'(((64'd1 << ODD_W) - 64'd1) / DAY_ODD);

  localparam logic [LEVEL_W-1:0] MARGIN_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUR_ENTRIES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAR_ENTRIES = 2'd2;

  typedef enum logic [1:0] {
    CMD_WAKE     = 2'd0,
    CMD_RESUME   = 2'd1,
    CMD_LOAD_DUR = 2'd2,
    CMD_LOAD_MAR = 2'd3
  } bwsp_cmd_e;

  typedef enum logic [1:0] {
    ACT_SLEEP_INDEF = 2'd0,
    ACT_SLEEP_TIMED = 2'd1,
    ACT_SHUTDOWN    = 2'd2
  } bwsp_act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } bwsp_state_e;

  typedef struct packed {
    bwsp_cmd_e           command;
    logic [LEVEL_W-1:0]  charge_level;
    logic                line_power;
    logic [SLOT_W-1:0]   entry_index;
    logic [SEC_W-1:0]    entry_value;
  } bwsp_item_t;

  typedef struct packed {
    bwsp_act_e                action;
    logic [SEC_W-1:0]         sleep_seconds;
    logic signed [THR_W-1:0]  threshold_now;
    logic                     status;
  } bwsp_result_t;

  // table write broadcast to the cells
  typedef struct packed {
    logic               dur_we;
    logic               mar_we;
    logic [LEVEL_W-1:0] key;
    logic [SEC_W-1:0]   dur_sec;
    logic [LEVEL_W-1:0] mar_amt;
  } bwsp_wr_t;

  // which tables a cell takes part in
  typedef struct packed {
    logic dur_en;
    logic mar_en;
  } bwsp_en_t;

  // running lookup candidates handed from cell to cell
  typedef struct packed {
    logic               tok;
    logic               d_found;
    logic [LEVEL_W-1:0] d_best_key;
    logic [SEC_W-1:0]   d_best_sec;
    logic               d_seen;
    logic [LEVEL_W-1:0] d_low_key;
    logic [SEC_W-1:0]   d_low_sec;
    logic               m_found;
    logic [LEVEL_W-1:0] m_best_key;
    logic [LEVEL_W-1:0] m_best_amt;
    logic               m_seen;
    logic [LEVEL_W-1:0] m_low_key;
    logic [LEVEL_W-1:0] m_low_amt;
  } bwsp_cand_t;

endpackage

FILE: src/bwsp_cell.sv
// One table slot of both tables plus one registered step of the lookup chain.
module bwsp_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bwsp_pkg::bwsp_wr_t           wr_i,
  input  bwsp_pkg::bwsp_en_t           en_i,
  input  logic [bwsp_pkg::LEVEL_W-1:0] level_i,
  input  bwsp_pkg::bwsp_cand_t         cand_i,
  output bwsp_pkg::bwsp_cand_t         cand_o
);
  import bwsp_pkg::*;

  logic [LEVEL_W-1:0] dkey_q;
  logic [SEC_W-1:0]   dsec_q;
  logic [LEVEL_W-1:0] mkey_q;
  logic [LEVEL_W-1:0] mamt_q;
  bwsp_cand_t         cand_d;
  bwsp_cand_t         cand_q;
  logic               tok_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.dur_we) begin
      dkey_q <= wr_i.key;
      dsec_q <= wr_i.dur_sec;
    end
    if (wr_i.mar_we) begin
      mkey_q <= wr_i.key;
      mamt_q <= wr_i.mar_amt;
    end
  end

  // ties go to the later slot for best, the earlier slot for lowest
  always_comb begin
    cand_d = cand_i;
    if (en_i.dur_en) begin
      if (dkey_q <= level_i && (!cand_i.d_found || dkey_q >= cand_i.d_best_key)) begin
        cand_d.d_found    = 1'b1;
        cand_d.d_best_key = dkey_q;
        cand_d.d_best_sec = dsec_q;
      end
      if (!cand_i.d_seen || dkey_q < cand_i.d_low_key) begin
        cand_d.d_seen    = 1'b1;
        cand_d.d_low_key = dkey_q;
        cand_d.d_low_sec = dsec_q;
      end
    end
    if (en_i.mar_en) begin
      if (mkey_q <= level_i && (!cand_i.m_found || mkey_q >= cand_i.m_best_key)) begin
        cand_d.m_found    = 1'b1;
        cand_d.m_best_key = mkey_q;
        cand_d.m_best_amt = mamt_q;
      end
      if (!cand_i.m_seen || mkey_q < cand_i.m_low_key) begin
        cand_d.m_seen    = 1'b1;
        cand_d.m_low_key = mkey_q;
        cand_d.m_low_amt = mamt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= cand_d.tok;
    end
  end

  always_comb begin
    cand_o     = cand_q;
    cand_o.tok = tok_q;
  end

endmodule

FILE: src/battery_wake_shutdown_policy_unit.sv
// Top level of the battery wake shutdown policy unit: control, state and cell chain.
//
// Usage
//   Input beat: item_i is taken at a rising edge with start high and busy low.
//   Result beat: result_o is valid for exactly one cycle while done_o is high;
//   the receiver cannot stall, so nothing waits on it.
//   Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 enable,
//   1 duration entries, 2 margin entries) at the edge; write only when idle.
// Sequencing
//   Wake check with the policy active: the token runs through the chain of
//   TABLE_DEPTH registered cells, and done_o is registered once the token
//   leaves the last cell. Both tables are searched in the same pass. All
//   other beats pass through ST_EXEC, which raises done_o (the duration check
//   registers its modular-inverse product first). busy drops in the cycle
//   done_o is high, so a new beat can start there; no new beat is taken while
//   one is still in progress.
// Reset
//   rst_ni clears config, threshold state and control; table slots hold
//   whatever was last loaded and must be written before use.
module battery_wake_shutdown_policy_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  bwsp_pkg::bwsp_item_t           item_i,
  output logic                           done_o,
  output bwsp_pkg::bwsp_result_t         result_o,
  input  logic                           cfg_we_i,
  input  logic [bwsp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bwsp_pkg::CNT_W-1:0]     cfg_data_i
);
  import bwsp_pkg::*;

  bwsp_state_e             state_q, state_d;
  bwsp_item_t              item_q, item_d;
  logic [ODD_W-1:0]        prod_q, prod_d;
  logic                    inj_q, inj_d;
  logic                    enable_q, enable_d;
  logic [CNT_W-1:0]        dcnt_q, dcnt_d;
  logic [CNT_W-1:0]        mcnt_q, mcnt_d;
  logic signed [THR_W-1:0] thr_q, thr_d;
  logic [LEVEL_W-1:0]      rem_q, rem_d;
  logic                    thr_valid_q, thr_valid_d;
  logic                    rejected_q, rejected_d;
  logic                    done_q, done_d;
  bwsp_result_t            res_q, res_d;

  logic                    active;
  logic                    day_multiple;
  logic                    wr_dur, wr_mar;
  bwsp_wr_t                wr_all;
  bwsp_cand_t              chain [TABLE_DEPTH+1];
  bwsp_cand_t              last;
  logic [TABLE_DEPTH-1:0]  tok_vec;
  logic [LEVEL_W-1:0]      margin;
  logic [SEC_W-1:0]        dur_sec;
  logic signed [THR_W-1:0] lvl_s;
  logic signed [THR_W-1:0] thr_new;
  logic signed [THR_W-1:0] thr_eff;
  logic [LEVEL_W-1:0]      rem_eff;

  assign busy = (state_q != ST_IDLE);

  // policy gate: enabled, both entry counts non-zero and no rejected duration load
  assign active = enable_q && (dcnt_q != '0) && (mcnt_q != '0) && !rejected_q;

  // zero or whole days: low 7 bits clear and odd part divisible by 675
  assign day_multiple = (item_q.entry_value[DAY_SHIFT-1:0] == '0) && (prod_q <= DAY_LIMIT);

  // ---------------------------------------------------------------------------
  // Cell chain: cell i holds slot i of both tables
  // ---------------------------------------------------------------------------
  assign wr_all.dur_we  = wr_dur;
  assign wr_all.mar_we  = wr_mar;
  assign wr_all.key     = item_q.charge_level;
  assign wr_all.dur_sec = item_q.entry_value;
  assign wr_all.mar_amt = (item_q.entry_value[SEC_W-1:LEVEL_W] != '0) ? MARGIN_MAX
                                                                       : item_q.entry_value[LEVEL_W-1:0];

  assign chain[0] = '{tok: inj_q, default: '0};

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    bwsp_wr_t wr_cell;
    bwsp_en_t en_cell;

    always_comb begin
      wr_cell        = wr_all;
      // slots past the depth match no cell and are dropped
      wr_cell.dur_we = wr_dur && (32'(item_q.entry_index) == i);
      wr_cell.mar_we = wr_mar && (32'(item_q.entry_index) == i);
    end

    // counts above the depth simply enable every cell
    assign en_cell.dur_en = (32'(dcnt_q) > i);
    assign en_cell.mar_en = (32'(mcnt_q) > i);

    bwsp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .wr_i    (wr_cell),
      .en_i    (en_cell),
      .level_i (item_q.charge_level),
      .cand_i  (chain[i]),
      .cand_o  (chain[i+1])
    );

    assign tok_vec[i] = chain[i+1].tok;
  end

  assign last = chain[TABLE_DEPTH];

  // ---------------------------------------------------------------------------
  // Threshold decision at the end of the chain
  // ---------------------------------------------------------------------------
  assign margin  = last.m_found ? last.m_best_amt : last.m_low_amt;
  assign dur_sec = last.d_found ? last.d_best_sec : last.d_low_sec;
  assign lvl_s   = $signed({1'b0, item_q.charge_level});
  assign thr_new = lvl_s - $signed({1'b0, margin});
  // first check after a resume uses the threshold it sets itself
  assign thr_eff = thr_valid_q ? thr_q : thr_new;
  assign rem_eff = thr_valid_q ? rem_q : item_q.charge_level;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    prod_d      = prod_q;
    inj_d       = 1'b0;
    enable_d    = enable_q;
    dcnt_d      = dcnt_q;
    mcnt_d      = mcnt_q;
    thr_d       = thr_q;
    rem_d       = rem_q;
    thr_valid_d = thr_valid_q;
    rejected_d  = rejected_q;
    done_d      = 1'b0;
    res_d       = res_q;
    wr_dur      = 1'b0;
    wr_mar      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          item_d = item_i;
          prod_d = ODD_W'(item_i.entry_value[SEC_W-1:DAY_SHIFT] * DAY_INV);
          if (item_i.command == CMD_WAKE && active) begin
            inj_d   = 1'b1;
            state_d = ST_SCAN;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end

      ST_EXEC: begin
        res_d.action        = ACT_SLEEP_INDEF;
        res_d.sleep_seconds = '0;
        res_d.status        = 1'b0;
        res_d.threshold_now = thr_q;
        unique case (item_q.command)
          CMD_WAKE: begin
            // policy inactive: answer sleep indefinitely, state untouched
          end
          CMD_RESUME: begin
            thr_d               = '0;
            rem_d               = '0;
            thr_valid_d         = 1'b0;
            res_d.threshold_now = '0;
          end
          CMD_LOAD_DUR: begin
            if (day_multiple) begin
              rejected_d   = 1'b1;
              res_d.status = 1'b1;
            end else begin
              wr_dur = 1'b1;
            end
          end
          CMD_LOAD_MAR: begin
            wr_mar = 1'b1;
          end
          default: begin
          end
        endcase
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end

      ST_SCAN: begin
        if (last.tok) begin
          res_d.status = 1'b0;
          if (!thr_valid_q) begin
            thr_d       = thr_new;
            rem_d       = item_q.charge_level;
            thr_valid_d = 1'b1;
          end
          if (lvl_s < thr_eff && !item_q.line_power) begin
            res_d.action        = ACT_SHUTDOWN;
            res_d.sleep_seconds = '0;
          end else begin
            if (item_q.charge_level > rem_eff) begin
              thr_d = thr_new;
              rem_d = item_q.charge_level;
            end
            res_d.action        = ACT_SLEEP_TIMED;
            res_d.sleep_seconds = dur_sec;
          end
          res_d.threshold_now = thr_d;
          done_d              = 1'b1;
          state_d             = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLE: begin
          enable_d = cfg_data_i[0];
        end
        CFG_DUR_ENTRIES: begin
          dcnt_d     = cfg_data_i;
          rejected_d = 1'b0;
        end
        CFG_MAR_ENTRIES: begin
          mcnt_d = cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      inj_q       <= 1'b0;
      enable_q    <= 1'b0;
      dcnt_q      <= '0;
      mcnt_q      <= '0;
      thr_q       <= '0;
      rem_q       <= '0;
      thr_valid_q <= 1'b0;
      rejected_q  <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      inj_q       <= inj_d;
      enable_q    <= enable_d;
      dcnt_q      <= dcnt_d;
      mcnt_q      <= mcnt_d;
      thr_q       <= thr_d;
      rem_q       <= rem_d;
      thr_valid_q <= thr_valid_d;
      rejected_q  <= rejected_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    prod_q <= prod_d;
    res_q  <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef ASSERT_OFF
  // a single lookup token in flight at most
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({inj_q, tok_vec}))
    else $error("more than one lookup token in the cell chain");

  // the token only runs while a scan is under way
  a_tok_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inj_q || tok_vec != '0) |-> state_q == ST_SCAN)
    else $error("lookup token outside a scan");

  // an accepted beat always makes the unit busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not start work");

  // sleep time only accompanies a timed sleep
  a_sec_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.action != ACT_SLEEP_TIMED) |-> result_o.sleep_seconds == '0)
    else $error("sleep seconds on a non-timed answer");

  // a rejected duration load answers sleep indefinitely and latches the flag
  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status) |-> (result_o.action == ACT_SLEEP_INDEF && rejected_q))
    else $error("rejection answer inconsistent");
`endif

endmodule
